/* design/spdif_subframe_encoder_core_assert.svh */
// Assertion macros used by the encoder core's RTL file.
`ifndef SPDIF_SUBFRAME_ENCODER_CORE_ASSERT_SVH
`define SPDIF_SUBFRAME_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPDIF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spdif encoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPDIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spdif encoder: next-cycle check failed");

`endif

/* design/spdif_pkg.sv */
`default_nettype none

package spdif_pkg;

    localparam int          FRAMES_PER_BLOCK_DEF = 192;
    localparam logic [7:0]  GAIN_RESET           = 8'd64;

    localparam logic [31:0] PRE_B     = 32'hCCE8_0000;
    localparam logic [31:0] PRE_M     = 32'hCCE2_0000;
    localparam logic [31:0] PRE_W     = 32'hCCE4_0000;
    localparam logic [31:0] AUX_PLAIN = 32'h0000_B333;
    localparam logic [31:0] AUX_FLIP  = 32'h0000_CCCC;

    localparam logic signed [17:0] SAT_MAX = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN = -18'sd32767;

    typedef struct packed {
        logic signed [15:0] left_pcm;
        logic signed [15:0] right_pcm;
    } frame_in_t;

    typedef struct packed {
        logic [31:0] left_data_word;
        logic [31:0] left_aux_word;
        logic [31:0] right_data_word;
        logic [31:0] right_aux_word;
        logic        block_start;
    } frame_out_t;

    typedef struct packed {
        logic en_mul;
        logic en_code;
    } lane_ctrl_t;

    // Biphase-mark code of one byte; the byte's LSB lands in the top two cells.
    function automatic logic [15:0] bmc_byte(input logic [7:0] b);
        logic [15:0] code;
        logic        nxt;
        logic        cell_end;
        logic        cell_start;
        code = '0;
        nxt  = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            cell_end         = ~nxt;
            cell_start       = b[i] ? ~cell_end : cell_end;
            code[15 - 2 * i] = cell_start;
            code[14 - 2 * i] = cell_end;
            nxt              = cell_start;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

/* design/spdif_subframe_encoder_core.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    frame_in_t: left and right samples
// out       output     out_valid / out_stall  frame_out_t: data and aux words, block start
// cfg       input      cfg_we                 cfg_wdata: gain, unsigned Q2.6
//
// One stereo frame is accepted every cycle while in_stall is low; each transaction passes
// through three registers to reach the output: the gain multiply register, the code register and the output register.
// Reset clears the stage valid flags and the frame counter and sets the gain to unity.
// in_stall rises only when all three stages hold a frame and out_stall is high.
// The two channels run in identical lanes that share the gain register.
`default_nettype none

module spdif_subframe_encoder_core
    import spdif_pkg::*;
#(
    parameter int FRAMES_PER_BLOCK = FRAMES_PER_BLOCK_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire frame_in_t  in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output frame_out_t      out_data
);

`include "spdif_subframe_encoder_core_assert.svh"

    logic [7:0]  gain_reg;
    logic        v1_reg;
    logic        v1_next;
    logic        v2_reg;
    logic        v2_next;
    logic        accept;
    logic        adv1;
    logic        adv2;
    logic        out_ready;
    lane_ctrl_t  ctrl;
    logic [31:0] left_data;
    logic [31:0] right_data;

    always_comb
    begin
        out_ready = !out_valid || !out_stall;
        adv2      = v2_reg && out_ready;
        adv1      = v1_reg && (!v2_reg || adv2);
        in_stall  = v1_reg && !adv1;
        accept    = in_valid && !in_stall;
        v1_next   = accept ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
        v2_next   = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_reg);
        ctrl.en_mul  = accept;
        ctrl.en_code = adv1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_wdata;
            end
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    spdif_lane u_lane_left
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (in_data.left_pcm),
        .gain      (gain_reg),
        .data_word (left_data)
    );

    spdif_lane u_lane_right
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (in_data.right_pcm),
        .gain      (gain_reg),
        .data_word (right_data)
    );

    spdif_merge #(
        .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK)
    ) u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (adv2),
        .stall      (out_stall),
        .left_data  (left_data),
        .right_data (right_data),
        .valid      (out_valid),
        .frame      (out_data)
    );

    `SPDIF_ASSERT_SAME(a_stall_when_full, clk, rst_n, in_stall, v2_reg && out_valid && out_stall)
    `SPDIF_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, accept, v1_reg)
    `SPDIF_ASSERT_NEXT(a_drain_empty, clk, rst_n, out_valid && !out_stall && !v2_reg, !out_valid)
    `SPDIF_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

`default_nettype wire

/* design/spdif_lane.sv */
`default_nettype none

module spdif_lane
    import spdif_pkg::*;
(
    input  wire logic               clk,
    input  wire lane_ctrl_t         ctrl,
    input  wire logic signed [15:0] sample,
    input  wire logic [7:0]         gain,
    output logic [31:0]             data_word
);

    logic signed [23:0] prod_full;
    logic signed [23:0] prod_reg;
    logic signed [17:0] shifted;
    logic signed [15:0] clamped;
    logic signed [15:0] biased;
    logic [15:0]        word;
    logic [15:0]        code_hi;
    logic [15:0]        code_lo;
    logic [31:0]        data_next;
    logic [31:0]        data_reg;

    assign prod_full = sample * $signed({1'b0, gain});

    always_comb
    begin
        shifted = $signed(prod_reg[23:6]);
        if (shifted > SAT_MAX)
        begin
            clamped = SAT_MAX[15:0];
        end
        else if (shifted < SAT_MIN)
        begin
            clamped = SAT_MIN[15:0];
        end
        else
        begin
            clamped = shifted[15:0];
        end
        // Negative values are biased so the shift rounds toward zero.
        biased  = clamped + (clamped[15] ? 16'sd15 : 16'sd0);
        word    = 16'(biased >>> 4);
        code_hi = bmc_byte(word[15:8]);
        code_lo = bmc_byte(word[7:0]);
        if (!code_hi[15])
        begin
            code_lo = ~code_lo;
        end
        data_next = {code_lo, code_hi};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            prod_reg <= prod_full;
        end
        if (ctrl.en_code)
        begin
            data_reg <= data_next;
        end
    end

    assign data_word = data_reg;

endmodule

`default_nettype wire

/* design/spdif_merge.sv */
`default_nettype none

module spdif_merge
    import spdif_pkg::*;
#(
    parameter int FRAMES_PER_BLOCK = FRAMES_PER_BLOCK_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic        stall,
    input  wire logic [31:0] left_data,
    input  wire logic [31:0] right_data,
    output logic             valid,
    output frame_out_t       frame
);

    localparam int              CW   = (FRAMES_PER_BLOCK > 2) ? $clog2(FRAMES_PER_BLOCK) : 1;
    localparam logic [CW-1:0]   LAST = CW'(FRAMES_PER_BLOCK - 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          valid_reg;
    logic          valid_next;
    frame_out_t    frame_reg;
    frame_out_t    frame_next;
    logic          start;

    always_comb
    begin
        start      = (count_reg == '0);
        count_next = count_reg;
        valid_next = valid_reg;
        if (load)
        begin
            count_next = (count_reg == LAST) ? '0 : count_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
        frame_next.left_data_word  = left_data;
        frame_next.left_aux_word   = (start ? PRE_B : PRE_M)
                                   | (left_data[31] ? AUX_FLIP : AUX_PLAIN);
        frame_next.right_data_word = right_data;
        frame_next.right_aux_word  = PRE_W | (right_data[31] ? AUX_FLIP : AUX_PLAIN);
        frame_next.block_start     = start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_next;
        end
    end

    assign valid = valid_reg;
    assign frame = frame_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb
    import spdif_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 80;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    frame_in_t  in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    frame_out_t out_data;

    frame_in_t  pending_frames[$];
    frame_out_t expected_frames[$];

    logic [7:0] gain_setting = GAIN_RESET;
    int         block_pos = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_req = 0;
    int         hold_ack = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    int         mismatches = 0;
    int         frames_sent = 0;
    int         frames_checked = 0;
    int         block_starts = 0;
    int         clipped_samples = 0;
    int         gains_used = 1;

    spdif_subframe_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cells are filled from bit 7 downwards, each pair ending opposite to the level after it.
    function automatic logic [15:0] biphase_cells(input logic [7:0] b);
        logic [15:0] cells;
        logic [1:0]  pair;
        logic        follow;
        cells  = '0;
        follow = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            pair = {b[i] ? follow : ~follow, ~follow};
            cells[15 - 2 * i -: 2] = pair;
            follow = pair[1];
        end
        return cells;
    endfunction

    function automatic void code_channel(input logic signed [15:0] s,
                                         output logic [31:0] data_word,
                                         output logic [15:0] aux_bits);
        int          scaled;
        logic [15:0] word;
        logic [15:0] hi_cells;
        logic [15:0] lo_cells;
        scaled = (int'(s) * int'({24'd0, gain_setting})) >>> 6;
        if (scaled > 32767 || scaled < -32767)
            clipped_samples++;
        if (scaled > 32767)
            scaled = 32767;
        else if (scaled < -32767)
            scaled = -32767;
        scaled   = scaled / 16;
        word     = scaled[15:0];
        hi_cells = biphase_cells(word[15:8]);
        lo_cells = biphase_cells(word[7:0]);
        if (!hi_cells[15])
            lo_cells = ~lo_cells;
        data_word = {lo_cells, hi_cells};
        aux_bits  = lo_cells[15] ? AUX_FLIP[15:0] : AUX_PLAIN[15:0];
    endfunction

    function automatic frame_out_t predict_frame(input frame_in_t f);
        frame_out_t  r;
        logic [15:0] aux_bits;
        logic        first;
        first = (block_pos == 0);
        code_channel(f.left_pcm, r.left_data_word, aux_bits);
        r.left_aux_word = (first ? PRE_B : PRE_M) | {16'd0, aux_bits};
        code_channel(f.right_pcm, r.right_data_word, aux_bits);
        r.right_aux_word = PRE_W | {16'd0, aux_bits};
        r.block_start    = first;
        block_pos = (block_pos + 1 >= FRAMES_PER_BLOCK_DEF) ? 0 : block_pos + 1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_frames.push_back(predict_frame(in_data));
                frames_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_frames.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("output transaction with no frame outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("left_data_word", want.left_data_word, out_data.left_data_word);
                    check_field("left_aux_word", want.left_aux_word, out_data.left_aux_word);
                    check_field("right_data_word", want.right_data_word,
                                out_data.right_data_word);
                    check_field("right_aux_word", want.right_aux_word, out_data.right_aux_word);
                    check_field("block_start", {31'd0, want.block_start},
                                {31'd0, out_data.block_start});
                    frames_checked++;
                    if (want.block_start)
                        block_starts++;
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [15:0] random_sample();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = int'($urandom_range(600)) - 300;
            7:             v = 32767 - int'($urandom_range(300));
            8:             v = -32768 + int'($urandom_range(300));
            default:
            begin
                case ($urandom_range(3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    default: v = 0;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    task automatic push_pair(input int l, input int r);
        frame_in_t f;
        f.left_pcm  = l[15:0];
        f.right_pcm = r[15:0];
        pending_frames.push_back(f);
    endtask

    task automatic push_random(input int n);
        frame_in_t f;
        for (int i = 0; i < n; i++)
        begin
            f.left_pcm  = random_sample();
            f.right_pcm = random_sample();
            pending_frames.push_back(f);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_frames.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic start_phase(input logic [7:0] g, input int send_pct, input int recv_pct);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we       <= 1'b0;
        gain_setting = g;
        gains_used++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        push_pair(0, 0);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(-1, 1);
        push_pair(-16, 16);
        push_pair(-17, 17);
        push_pair(15, -15);
        push_pair(16'h5555, 16'hAAAA);
        push_pair(16'h00FF, -256);

        start_phase(8'd255, 0, 0);
        push_pair(32767, -32768);
        push_pair(8224, -8224);
        push_pair(128, -129);
        push_pair(-32767, 1);
        push_random(240);

        start_phase(8'd0, 65, 0);
        push_pair(32767, -32768);
        push_pair(-1, 1);
        push_random(120);

        start_phase(8'($urandom_range(255)), 0, 65);
        push_random(260);
        hold_req++;

        start_phase(8'd1, 9, 9);
        push_random(150);

        start_phase(8'd128, 65, 0);
        push_random(150);

        start_phase(8'($urandom_range(255)), 0, 65);
        push_random(200);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Encoded %0d stereo frames (%0d checked) under %0d gain settings.",
                 frames_sent, frames_checked, gains_used);
        $display("%0d frames opened a block and %0d samples were clipped.",
                 block_starts, clipped_samples);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
